@@ design/bvmmd_pkg.sv @@
// Shared types and constants of the banked video memory map decoder.
package bvmmd_pkg;

  // Bus access kinds carried in the mode field.
  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_WRITE     = 3'd1,
    MODE_SET_MAP   = 3'd2,
    MODE_SET_PAGE  = 3'd3,
    MODE_SET_STRB  = 3'd4,
    MODE_SET_BANK  = 3'd5,
    MODE_SET_LATCH = 3'd6,
    MODE_READ_MAP  = 3'd7
  } mode_t;

  // Which memory answered the access.
  typedef enum logic [2:0] {
    ROUTE_FLAT  = 3'd0,
    ROUTE_MAP   = 3'd1,
    ROUTE_BANK  = 3'd2,
    ROUTE_CHAR  = 3'd3,
    ROUTE_DROP  = 3'd4
  } route_t;

  // Where the read byte of a finished word comes from.
  typedef enum logic [1:0] {
    SRC_REG   = 2'd0,
    SRC_PLANE = 2'd1,
    SRC_CHAR  = 2'd2
  } src_t;

  localparam logic [15:0] CHAR_WIN_MASK = 16'hF800;
  localparam logic [15:0] CHAR_WIN_BASE = 16'h7800;
  localparam logic [7:0]  MAP_INVERT    = 8'hFF;
  localparam int          CHAR_ADDR_BITS = 11;
  localparam int          PAGE_COUNT     = 16;

  localparam int IN_BYTES  = 7;   // 51 payload bits
  localparam int OUT_BYTES = 3;   // 19 payload bits

endpackage

@@ design/banked_video_memory_map_decoder_unit.sv @@
// Top level: bus access decoder owning video plane, character and attribute RAMs.
// The single-port RAM read of the access stage is registered, and the block holds
// one word between accept and result; the result is then registered at the output,
//   and no new word is taken while a word is held or a result waits unread.
// Reset (rst, synchronous, active high) clears all control registers and starts a
//   clearing pass over every plane address (the character and attribute RAM is
//   cleared while the pass is in its first 2048 addresses); no word is accepted
//   until it ends.
module banked_video_memory_map_decoder_unit
  import bvmmd_pkg::*;
#(
  parameter int PLANE_ADDR_BITS = 17,   // 15..19
  parameter int FETCH_WINDOW    = 4     // 1..4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] mode, [18:3] address, [26:19] data, [42:27] fetch_pc, [50:43] flat_data
  input  logic [IN_BYTES*8-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] read_data, [10:8] route, [18:11] attribute_value
  output logic [OUT_BYTES*8-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------- input word
  mode_t       in_mode;
  logic [15:0] in_address;
  logic [7:0]  in_data;
  logic [15:0] in_pc;
  logic [7:0]  in_flat;

  assign in_mode    = mode_t'(s_axis_tdata[2:0]);
  assign in_address = s_axis_tdata[18:3];
  assign in_data    = s_axis_tdata[26:19];
  assign in_pc      = s_axis_tdata[42:27];
  assign in_flat    = s_axis_tdata[50:43];

  // ---------------------------------------------------------------- control state
  logic [7:0] page_table [PAGE_COUNT];
  logic       paging_enable;
  logic       strobe_level;
  logic [7:0] bank_select;
  logic       attribute_hold_en;
  logic [7:0] attribute_hold;
  logic [7:0] attribute_hold_next;

  // Reset clearing pass over all RAMs.
  logic                       clearing;
  logic [PLANE_ADDR_BITS-1:0] clr_cnt;
  logic                       char_clr;

  // Access stage holds one word while the RAM read completes.
  logic       busy;
  logic       accept;
  route_t     pend_route;
  src_t       pend_src;
  logic [7:0] pend_value;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !clearing && !busy && (!m_axis_tvalid || m_axis_tready);

  // ---------------------------------------------------------------- decode
  // The page table has one read port: page number for bus accesses, low nibble
  // for the map-read mode.
  logic [3:0]  pt_idx;
  logic [7:0]  pt_raw;
  logic [7:0]  pt_entry;
  logic        map_hit;
  logic        bank_hit;
  logic        char_win;
  logic        own_fetch;
  logic [16:0] pc_diff;
  logic [18:0] map_phys;
  logic [18:0] bank_phys;

  assign pt_idx   = (in_mode == MODE_READ || in_mode == MODE_WRITE) ?
                    in_address[15:12] : in_address[3:0];
  assign pt_raw   = page_table[pt_idx];
  assign pt_entry = pt_raw ^ MAP_INVERT;       // map is stored inverted
  assign map_hit  = paging_enable && !pt_entry[7];
  assign bank_hit = !strobe_level && !in_address[15];
  assign char_win = (in_address & CHAR_WIN_MASK) == CHAR_WIN_BASE;

  // Plane addresses wrap at the plane size.
  assign map_phys  = {pt_entry[6:0], in_address[11:0]};
  assign bank_phys = {bank_select[7:4], in_address[14:0]};

  // Opcode fetches run from the character window: reads within the fetch
  // window past the PC go to flat memory and leave the attribute latch alone.
  assign pc_diff   = {1'b0, in_address} - {1'b0, in_pc};
  assign own_fetch = ((in_pc & CHAR_WIN_MASK) == CHAR_WIN_BASE) && !pc_diff[16] &&
                     (pc_diff[15:0] < 16'(FETCH_WINDOW));

  route_t     dec_route;
  src_t       dec_src;
  logic [7:0] dec_value;
  logic       dec_plane_we;
  logic       dec_char_we;

  always_comb begin
    dec_route    = ROUTE_FLAT;
    dec_src      = SRC_REG;
    dec_value    = 8'h00;
    dec_plane_we = 1'b0;
    dec_char_we  = 1'b0;
    unique case (in_mode)
      MODE_READ: begin
        priority if (map_hit) begin
          dec_route = ROUTE_MAP;
          dec_src   = SRC_PLANE;
        end else if (bank_hit) begin
          dec_route = ROUTE_BANK;
          dec_src   = SRC_PLANE;
        end else if (char_win && !own_fetch) begin
          dec_route = ROUTE_CHAR;
          dec_src   = SRC_CHAR;
        end else begin
          dec_value = in_flat;
        end
      end
      MODE_WRITE: begin
        priority if (map_hit) begin
          dec_route    = ROUTE_MAP;
          dec_plane_we = 1'b1;
        end else if (bank_hit) begin
          dec_route    = ROUTE_BANK;
          dec_plane_we = 1'b1;
        end else if (char_win) begin
          dec_route   = ROUTE_CHAR;
          dec_char_we = 1'b1;
        end else if (!in_address[15]) begin
          dec_route = ROUTE_DROP;
        end else begin
          dec_route = ROUTE_FLAT;    // flat memory takes high writes itself
        end
      end
      MODE_READ_MAP: begin
        dec_value = pt_raw;
      end
      default: begin
        // register writes, handled below; report zero on flat route
      end
    endcase
  end

  // ---------------------------------------------------------------- RAMs
  logic [PLANE_ADDR_BITS-1:0] plane_addr;
  logic                       plane_we;
  logic [7:0]                 plane_wdata;
  logic [7:0]                 plane_rdata;
  logic [CHAR_ADDR_BITS-1:0]  char_addr;
  logic                       char_we;
  logic [7:0]                 char_wdata;
  logic [7:0]                 char_rdata;
  logic [7:0]                 attr_wdata;
  logic [7:0]                 attr_rdata;
  logic [15:0]                char_attr_rdata;

  assign char_clr    = clearing &&
                       (clr_cnt[PLANE_ADDR_BITS-1:CHAR_ADDR_BITS] == '0);

  assign plane_addr  = clearing ? clr_cnt :
                       (map_hit ? map_phys[PLANE_ADDR_BITS-1:0]
                                : bank_phys[PLANE_ADDR_BITS-1:0]);
  assign plane_we    = clearing || (accept && dec_plane_we);
  assign plane_wdata = clearing ? 8'h00 : in_data;

  assign char_addr   = clearing ? clr_cnt[CHAR_ADDR_BITS-1:0]
                                : in_address[CHAR_ADDR_BITS-1:0];
  assign char_we     = char_clr || (accept && dec_char_we);
  assign char_wdata  = clearing ? 8'h00 : in_data;
  // a character write stores the latched attribute beside it
  assign attr_wdata  = clearing ? 8'h00 : attribute_hold;

  // character in the low byte, its attribute in the high byte
  assign char_rdata  = char_attr_rdata[7:0];
  assign attr_rdata  = char_attr_rdata[15:8];

  bvmmd_ram #(.WIDTH(8), .ADDR_BITS(PLANE_ADDR_BITS)) u_plane (
    .clk   (clk),
    .we    (plane_we),
    .addr  (plane_addr),
    .wdata (plane_wdata),
    .rdata (plane_rdata)
  );

  bvmmd_ram #(.WIDTH(16), .ADDR_BITS(CHAR_ADDR_BITS)) u_char (
    .clk   (clk),
    .we    (char_we),
    .addr  (char_addr),
    .wdata ({attr_wdata, char_wdata}),
    .rdata (char_attr_rdata)
  );

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        page_table[i] <= 8'h00;
      end
      paging_enable <= 1'b0;
      strobe_level  <= 1'b1;
      bank_select   <= 8'h00;
    end else if (accept) begin
      unique case (in_mode)
        MODE_SET_MAP:  page_table[in_address[3:0]] <= in_data;
        MODE_SET_PAGE: paging_enable <= in_data[0];
        MODE_SET_STRB: strobe_level  <= in_data[0];
        MODE_SET_BANK: bank_select   <= in_data;
        default: begin
        end
      endcase
    end
  end

  // Latch loads on set-latch at accept, or from attribute RAM when a character
  // read completes.
  always_comb begin
    attribute_hold_en   = 1'b0;
    attribute_hold_next = attribute_hold;
    if (busy && pend_src == SRC_CHAR) begin
      attribute_hold_en   = 1'b1;
      attribute_hold_next = attr_rdata;
    end else if (accept && in_mode == MODE_SET_LATCH) begin
      attribute_hold_en   = 1'b1;
      attribute_hold_next = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_hold <= 8'h00;
    end else if (attribute_hold_en) begin
      attribute_hold <= attribute_hold_next;
    end
  end

  // access stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_route <= dec_route;
      pend_src   <= dec_src;
      pend_value <= dec_value;
    end
  end

  // ---------------------------------------------------------------- result word
  logic [7:0] res_data;

  always_comb begin
    unique case (pend_src)
      SRC_PLANE: res_data = plane_rdata;
      SRC_CHAR:  res_data = char_rdata;
      default:   res_data = pend_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      busy <= accept;
      if (busy) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      m_axis_tdata <= {5'b0, attribute_hold_next, pend_route, res_data};
    end
  end

  // ---------------------------------------------------------------- checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("word accepted during RAM clearing pass");

  a_accept_then_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 m_axis_tvalid)
    else $error("accepted word did not produce a result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept && !(m_axis_tvalid && !m_axis_tready && $past(m_axis_tvalid) &&
                          $past(accept)))
    else $error("second word entered access stage");

  a_ram_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    !clearing && accept |-> !(dec_plane_we && dec_char_we))
    else $error("access wrote both plane and character RAM");

endmodule

@@ design/bvmmd_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module bvmmd_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ tb/sv/banked_video_memory_map_decoder_unit_test.sv @@
// Self-checking stream testbench for the banked video memory map decoder.
module banked_video_memory_map_decoder_unit_test
  import bvmmd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_BITS = 17;
  localparam int FETCH_WIN  = 4;
  // Silence limit: the clearing pass after reset walks the whole plane first.
  localparam int STALL_LIMIT = 4 * (1 << PLANE_BITS);

  // One bus access as the sender sees it; sync marks a drain point.
  typedef struct {
    mode_t       op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] pc;
    logic [7:0]  flat;
    bit          sync;
  } bus_access_t;

  typedef struct {
    logic [7:0] rd;
    route_t     route;
    logic [7:0] attr;
  } decode_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [2:0] mode, [18:3] address, [26:19] data, [42:27] fetch_pc, [50:43] flat_data
  logic [IN_BYTES*8-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [7:0] read_data, [10:8] route, [18:11] attribute_value
  logic [OUT_BYTES*8-1:0] m_axis_tdata;

  banked_video_memory_map_decoder_unit #(
    .PLANE_ADDR_BITS(PLANE_BITS),
    .FETCH_WINDOW   (FETCH_WIN)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow copy of the decoder state.
  logic [7:0] shadow_map [PAGE_COUNT];
  logic       paging_on;
  logic       strobe_on;
  logic [7:0] bank_reg;
  logic [7:0] shadow_attr;
  logic [7:0] plane_mem [1 << PLANE_BITS];
  logic [7:0] char_mem  [1 << CHAR_ADDR_BITS];
  logic [7:0] attr_mem  [1 << CHAR_ADDR_BITS];

  bus_access_t    bus_accesses[$];     // words still to send
  decode_result_t pending_results[$];  // expected output words, oldest first
  bus_access_t    cur_word;            // word now offered on the slave side
  int unsigned    words_sent  = 0;
  int unsigned    words_taken = 0;
  int unsigned    error_count = 0;
  int unsigned    idle_cycles = 0;
  logic           calm;

  // No random idling on either side for a stretch in the middle of the run.
  assign calm = (words_taken >= 400) && (words_taken < 650);

  initial begin
    forever #1 clk = ~clk;
  end

  // Decode one access against the shadow state and update it.
  function automatic decode_result_t decode_access(bus_access_t acc);
    decode_result_t        res;
    logic [7:0]            entry;
    logic [18:0]           wide;
    logic [PLANE_BITS-1:0] paddr;
    logic [10:0]           char_idx;
    logic                  map_hit;
    logic                  bank_hit;
    logic                  char_hit;
    logic                  own_fetch;
    int unsigned           pc_end;
    entry     = shadow_map[acc.addr[15:12]] ^ MAP_INVERT;
    map_hit   = paging_on && !entry[7];
    bank_hit  = !strobe_on && !acc.addr[15];
    char_hit  = (acc.addr & CHAR_WIN_MASK) == CHAR_WIN_BASE;
    pc_end    = 32'(acc.pc) + FETCH_WIN;
    // Instruction fetch from the character window itself goes to flat memory.
    own_fetch = (acc.pc >= CHAR_WIN_BASE) && (acc.pc <= 16'h7FFF) &&
                (acc.addr >= acc.pc) && (32'(acc.addr) < pc_end);
    if (map_hit) begin
      wide = {entry[6:0], acc.addr[11:0]};
    end else begin
      wide = {bank_reg[7:4], acc.addr[14:0]};
    end
    paddr     = wide[PLANE_BITS-1:0];  // plane wraps at its size
    char_idx  = acc.addr[10:0];
    res.rd    = 8'h00;
    res.route = ROUTE_FLAT;
    case (acc.op)
      MODE_READ: begin
        if (map_hit) begin
          res.rd    = plane_mem[paddr];
          res.route = ROUTE_MAP;
        end else if (bank_hit) begin
          res.rd    = plane_mem[paddr];
          res.route = ROUTE_BANK;
        end else if (char_hit && !own_fetch) begin
          shadow_attr = attr_mem[char_idx];
          res.rd      = char_mem[char_idx];
          res.route   = ROUTE_CHAR;
        end else begin
          res.rd = acc.flat;
        end
      end
      MODE_WRITE: begin
        if (map_hit) begin
          plane_mem[paddr] = acc.data;
          res.route        = ROUTE_MAP;
        end else if (bank_hit) begin
          plane_mem[paddr] = acc.data;
          res.route        = ROUTE_BANK;
        end else if (char_hit) begin
          char_mem[char_idx] = acc.data;
          attr_mem[char_idx] = shadow_attr;
          res.route          = ROUTE_CHAR;
        end else if (!acc.addr[15]) begin
          res.route = ROUTE_DROP;
        end
      end
      MODE_SET_MAP:   shadow_map[acc.addr[3:0]] = acc.data;
      MODE_SET_PAGE:  paging_on = acc.data[0];
      MODE_SET_STRB:  strobe_on = acc.data[0];
      MODE_SET_BANK:  bank_reg = acc.data;
      MODE_SET_LATCH: shadow_attr = acc.data;
      default:        res.rd = shadow_map[acc.addr[3:0]];
    endcase
    res.attr = shadow_attr;
    return res;
  endfunction

  function automatic bus_access_t access(mode_t op, logic [15:0] addr, logic [7:0] data,
                                         logic [15:0] pc, logic [7:0] flat);
    bus_access_t acc;
    acc.op   = op;
    acc.addr = addr;
    acc.data = data;
    acc.pc   = pc;
    acc.flat = flat;
    acc.sync = 1'b0;
    return acc;
  endfunction

  function automatic bus_access_t drain_point();
    bus_access_t acc;
    acc      = access(MODE_READ, 16'h0000, 8'h00, 16'h0000, 8'h00);
    acc.sync = 1'b1;
    return acc;
  endfunction

  // Address mix: character window, low 32K, high half, anything.
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2: return CHAR_WIN_BASE | 16'($urandom_range(0, 16'h07FF));
      3, 4:    return 16'($urandom_range(0, 16'h7FFF));
      5, 6:    return 16'($urandom_range(16'h8000, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  // Fetch address: often just below the access so the fetch window edges get hit.
  function automatic logic [15:0] pick_pc(logic [15:0] addr);
    case ($urandom_range(0, 4))
      0, 1:    return addr - 16'($urandom_range(0, FETCH_WIN + 1));
      2:       return CHAR_WIN_BASE | 16'($urandom_range(0, 16'h07FF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bus_access_t random_access();
    logic [15:0] addr;
    int unsigned pick;
    addr = pick_addr();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return access(MODE_READ, addr, 8'($urandom), pick_pc(addr), 8'($urandom));
    end else if (pick < 65) begin
      return access(MODE_WRITE, addr, 8'($urandom), pick_pc(addr), 8'($urandom));
    end else if (pick < 73) begin
      return access(MODE_SET_MAP, addr, 8'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 79) begin
      return access(MODE_SET_PAGE, addr, 8'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      return access(MODE_SET_STRB, addr, 8'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      return access(MODE_SET_BANK, addr, 8'($urandom), 16'($urandom), 8'($urandom));
    end else if (pick < 95) begin
      return access(MODE_SET_LATCH, addr, 8'($urandom), 16'($urandom), 8'($urandom));
    end
    return access(MODE_READ_MAP, addr, 8'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  // Sender: a word stays up until taken; a drain point holds off until all
  // expected words are back.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (words_sent == words_taken) begin
      if (bus_accesses.size() != 0 && bus_accesses[0].sync && pending_results.size() == 0) begin
        void'(bus_accesses.pop_front());
      end
      if (bus_accesses.size() == 0 || bus_accesses[0].sync ||
          (!calm && $urandom_range(0, 99) < 13)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_word      = bus_accesses.pop_front();
        s_axis_tdata  <= {5'd0, cur_word.flat, cur_word.pc, cur_word.data,
                          cur_word.addr, cur_word.op};
        s_axis_tvalid <= 1'b1;
        words_sent++;
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Monitor: check finished words, predict on accepted ones.
  always @(posedge clk) begin
    decode_result_t want;
    decode_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.rd    = m_axis_tdata[7:0];
      got.route = route_t'(m_axis_tdata[10:8]);
      got.attr  = m_axis_tdata[18:11];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, got rd=%02h route=%0d attr=%02h",
                 $time, got.rd, got.route, got.attr);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.rd !== want.rd) begin
          $display("%0t: read_data expected %02h got %02h", $time, want.rd, got.rd);
          error_count++;
        end
        if (got.route !== want.route) begin
          $display("%0t: route expected %0d got %0d", $time, want.route, got.route);
          error_count++;
        end
        if (got.attr !== want.attr) begin
          $display("%0t: attribute_value expected %02h got %02h", $time, want.attr, got.attr);
          error_count++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(decode_access(cur_word));
      words_taken++;
    end
  end

  // Watchdog on handshake silence.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    foreach (shadow_map[i]) shadow_map[i] = 8'h00;
    foreach (plane_mem[i]) plane_mem[i] = 8'h00;
    foreach (char_mem[i]) begin
      char_mem[i] = 8'h00;
      attr_mem[i] = 8'h00;
    end
    paging_on   = 1'b0;
    strobe_on   = 1'b1;
    bank_reg    = 8'h00;
    shadow_attr = 8'h00;

    // Directed: fresh-state decode, low write drop, high write passthrough.
    bus_accesses.push_back(access(MODE_READ,  16'h0000, 8'h00, 16'h0000, 8'hFF));
    bus_accesses.push_back(access(MODE_WRITE, 16'h1234, 8'hFF, 16'hFFFF, 8'h00));
    bus_accesses.push_back(access(MODE_WRITE, 16'hFFFF, 8'h00, 16'h0000, 8'hFF));
    bus_accesses.push_back(access(MODE_READ,  16'hFFFF, 8'hFF, 16'hFFFF, 8'h00));
    // Character window: write stores the latch, read brings it back.
    bus_accesses.push_back(access(MODE_SET_LATCH, 16'h0000, 8'hA5, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_WRITE, 16'h7800, 8'h41, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_SET_LATCH, 16'hFFFF, 8'h00, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_READ,  16'h7800, 8'h00, 16'h0000, 8'h11));
    // Own fetch: inside, at the top edge, and one past the fetch window.
    bus_accesses.push_back(access(MODE_READ,  16'h7FFF, 8'h00, 16'h7FFE, 8'h22));
    bus_accesses.push_back(access(MODE_READ,  16'h7803, 8'h00, 16'h7800, 8'h33));
    bus_accesses.push_back(access(MODE_READ,  16'h7804, 8'h00, 16'h7800, 8'h44));
    // Writes in the window reach the store even under a fetch.
    bus_accesses.push_back(access(MODE_WRITE, 16'h7801, 8'h7E, 16'h7800, 8'h00));
    // Page map diversion, including a plane address that wraps.
    bus_accesses.push_back(access(MODE_SET_MAP,  16'h000F, 8'h80, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_SET_MAP,  16'hFFF0, 8'hFF, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_SET_PAGE, 16'h0000, 8'hFF, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_WRITE,    16'hF123, 8'h5A, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_READ,     16'hF123, 8'h00, 16'h0000, 8'h66));
    bus_accesses.push_back(access(MODE_READ_MAP, 16'hFFFF, 8'h00, 16'h0000, 8'h00));
    // Bank window with strobe low; map still wins on page 0.
    bus_accesses.push_back(access(MODE_SET_STRB, 16'h0000, 8'hFE, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_SET_BANK, 16'h0000, 8'hF0, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_WRITE,    16'h7FFF, 8'hC3, 16'h7FFF, 8'h00));
    bus_accesses.push_back(access(MODE_READ,     16'h0000, 8'h00, 16'h0000, 8'h77));
    bus_accesses.push_back(access(MODE_READ,     16'h8000, 8'h00, 16'h0000, 8'h88));
    bus_accesses.push_back(access(MODE_SET_PAGE, 16'h0000, 8'h02, 16'h0000, 8'h00));
    bus_accesses.push_back(access(MODE_SET_STRB, 16'h0000, 8'h01, 16'h0000, 8'h00));
    bus_accesses.push_back(drain_point());

    for (int i = 0; i < 1200; i++) begin
      if (i == 500 || i == 900) begin
        bus_accesses.push_back(drain_point());
      end
      bus_accesses.push_back(random_access());
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (bus_accesses.size() == 0 && words_sent == words_taken &&
          pending_results.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bvmmd_pkg.sv
design/bvmmd_ram.sv
design/banked_video_memory_map_decoder_unit.sv
tb/sv/banked_video_memory_map_decoder_unit_test.sv
